FILE: src/lk3_pkg.sv
// ----------------------------------------------------------------------------
// lk3_pkg
// Shared types, seeds and round steps of the lookup3 word hash pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lk3_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned MIX_STEPS  = 6;
    localparam int unsigned FINAL_STEPS = 7;
    localparam int unsigned ROUND_STEPS = MIX_STEPS + FINAL_STEPS;

    localparam logic [WORD_W-1:0] GOLDEN = 32'hdeadbeef;

    // Bias 127 less 32 for the 2^-32 scale
    localparam logic [7:0] EXP_OFFSET = 8'd95;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
    } hash_words_t;

    // Seed for an effective count of 1..4
    function automatic word_t seed_for(input logic [COUNT_W-1:0] count);
        word_t seed;
        seed = GOLDEN + word_t'({count, 2'b00}) + word_t'(13);
        return seed;
    endfunction

    function automatic word_t rotl(input word_t v, input int unsigned s);
        word_t r;
        r = (v << s) | (v >> (WORD_W - s));
        return r;
    endfunction

    // One line of the mix round or of the final avalanche.
    // Mix lines pass the words through unchanged when the mix is off.
    function automatic hash_words_t step_apply(
        input hash_words_t w,
        input int unsigned step,
        input logic        mix_on,
        input word_t       k3
    );
        hash_words_t r;
        r = w;
        if (step < MIX_STEPS && !mix_on)
        begin
            r = w;
        end
        else
        begin
            unique case (step)
                0:
                begin
                    r.a = (w.a - w.c) ^ rotl(w.c, 4);
                    r.c = w.c + w.b;
                end
                1:
                begin
                    r.b = (w.b - w.a) ^ rotl(w.a, 6);
                    r.a = w.a + w.c;
                end
                2:
                begin
                    r.c = (w.c - w.b) ^ rotl(w.b, 8);
                    r.b = w.b + w.a;
                end
                3:
                begin
                    r.a = (w.a - w.c) ^ rotl(w.c, 16);
                    r.c = w.c + w.b;
                end
                4:
                begin
                    r.b = (w.b - w.a) ^ rotl(w.a, 19);
                    r.a = w.a + w.c;
                end
                5:
                begin
                    // last mix line, then the fourth key goes into a
                    r.c = (w.c - w.b) ^ rotl(w.b, 4);
                    r.b = w.b + w.a + k3;
                    r.a = w.a + k3;
                    r.b = w.b + w.a;
                end
                6:  r.c = (w.c ^ w.b) - rotl(w.b, 14);
                7:  r.a = (w.a ^ w.c) - rotl(w.c, 11);
                8:  r.b = (w.b ^ w.a) - rotl(w.a, 25);
                9:  r.c = (w.c ^ w.b) - rotl(w.b, 16);
                10: r.a = (w.a ^ w.c) - rotl(w.c, 4);
                11: r.b = (w.b ^ w.a) - rotl(w.a, 14);
                12: r.c = (w.c ^ w.b) - rotl(w.b, 24);
                default: r = w;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/lk3_key_if.sv
// ----------------------------------------------------------------------------
// lk3_key_if
// Key channel: word count and four key words with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lk3_key_if;
    logic        valid;
    logic        ready;
    logic [2:0]  word_count;
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic [31:0] key_third;
    logic [31:0] key_fourth;

    modport source (
        output valid, word_count, key_first, key_second, key_third, key_fourth,
        input  ready
    );

    modport sink (
        input  valid, word_count, key_first, key_second, key_third, key_fourth,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/lk3_hash_if.sv
// ----------------------------------------------------------------------------
// lk3_hash_if
// Result channel: hash word and its unit-interval float bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lk3_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic [31:0] unit_float_bits;

    modport source (
        output valid, hash_value, unit_float_bits,
        input  ready
    );

    modport sink (
        input  valid, hash_value, unit_float_bits,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/lookup3_word_hash_to_unit.sv
// ----------------------------------------------------------------------------
// lookup3_word_hash_to_unit
// Stateless lookup3 word hash of one to four keys, with the hash also
// given as a single-precision value in the unit interval.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                        | handshake
//  key_in    | in  | word_count, key_first .. key_fourth            | valid/ready
//  hash_out  | out | hash_value, unit_float_bits                    | valid/ready
//
//  One transfer per cycle while results are taken; stages: input register,
//  seed stage, 13 round-line stages, three float stages (last is the
//  result register). A stalled result freezes the whole pipeline, bubbles
//  included; key_in.ready stays high unless a held result sits at the
//  output. Reset clears the valid bits only; no state survives items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lookup3_word_hash_to_unit
    import lk3_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lk3_key_if.sink   key_in,
    lk3_hash_if.source hash_out
);

    logic advance;
    logic res_valid;
    word_t res_hash;
    word_t res_float;

    // input register
    logic                in_valid_reg;
    logic [COUNT_W-1:0]  in_count_reg;
    word_t               in_k0_reg;
    word_t               in_k1_reg;
    word_t               in_k2_reg;
    word_t               in_k3_reg;

    // seed stage
    logic                seed_valid_reg;
    hash_words_t         seed_words_reg;
    hash_words_t         seed_words_next;
    logic                seed_mix_reg;
    word_t               seed_k3_reg;
    logic [COUNT_W-1:0]  eff_count;
    word_t               seed;

    logic        vld    [0:ROUND_STEPS];
    hash_words_t words  [0:ROUND_STEPS];
    logic        mix_on [0:ROUND_STEPS];
    word_t       k3     [0:ROUND_STEPS];

    assign advance      = !res_valid || hash_out.ready;
    assign key_in.ready = advance;

    always_comb
    begin
        priority if (in_count_reg == 3'd0)
        begin
            eff_count = 3'd1;
        end
        else if (in_count_reg > 3'd4)
        begin
            eff_count = 3'd4;
        end
        else
        begin
            eff_count = in_count_reg;
        end
    end

    assign seed = seed_for(eff_count);

    always_comb
    begin
        seed_words_next.a = seed + in_k0_reg;
        seed_words_next.b = seed + ((eff_count >= 3'd2) ? in_k1_reg : '0);
        seed_words_next.c = seed + ((eff_count >= 3'd3) ? in_k2_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            seed_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg   <= key_in.valid;
            seed_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_count_reg   <= key_in.word_count;
            in_k0_reg      <= key_in.key_first;
            in_k1_reg      <= key_in.key_second;
            in_k2_reg      <= key_in.key_third;
            in_k3_reg      <= key_in.key_fourth;
            seed_words_reg <= seed_words_next;
            seed_mix_reg   <= (eff_count == 3'd4);
            seed_k3_reg    <= in_k3_reg;
        end
    end

    assign vld[0]    = seed_valid_reg;
    assign words[0]  = seed_words_reg;
    assign mix_on[0] = seed_mix_reg;
    assign k3[0]     = seed_k3_reg;

    for (genvar i = 0; i < ROUND_STEPS; i++)
    begin : g_round
        lk3_round_stage #(
            .STEP (i)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (advance),
            .valid_in   (vld[i]),
            .words_in   (words[i]),
            .mix_on_in  (mix_on[i]),
            .k3_in      (k3[i]),
            .valid_out  (vld[i+1]),
            .words_out  (words[i+1]),
            .mix_on_out (mix_on[i+1]),
            .k3_out     (k3[i+1])
        );
    end

    lk3_unit_float u_float (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (vld[ROUND_STEPS]),
        .hash_in   (words[ROUND_STEPS].c),
        .valid_out (res_valid),
        .hash_out  (res_hash),
        .float_out (res_float)
    );

    assign hash_out.valid           = res_valid;
    assign hash_out.hash_value      = res_hash;
    assign hash_out.unit_float_bits = res_float;

endmodule

`default_nettype wire

FILE: src/lk3_round_stage.sv
// ----------------------------------------------------------------------------
// lk3_round_stage
// One registered line of the mix round or final avalanche.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lk3_round_stage
    import lk3_pkg::*;
#(
    parameter int unsigned STEP = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        valid_in,
    input  wire hash_words_t words_in,
    input  wire logic        mix_on_in,
    input  wire word_t       k3_in,
    output logic             valid_out,
    output hash_words_t      words_out,
    output logic             mix_on_out,
    output word_t            k3_out
);

    logic        valid_reg;
    hash_words_t words_reg;
    hash_words_t words_next;
    logic        mix_on_reg;
    word_t       k3_reg;

    always_comb
    begin
        words_next = step_apply(words_in, STEP, mix_on_in, k3_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            words_reg  <= words_next;
            mix_on_reg <= mix_on_in;
            k3_reg     <= k3_in;
        end
    end

    assign valid_out  = valid_reg;
    assign words_out  = words_reg;
    assign mix_on_out = mix_on_reg;
    assign k3_out     = k3_reg;

endmodule

`default_nettype wire

FILE: src/lk3_unit_float.sv
// ----------------------------------------------------------------------------
// lk3_unit_float
// Three-stage conversion of the hash to single-precision hash * 2^-32,
// round to nearest even; last stage is the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lk3_unit_float
    import lk3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  valid_in,
    input  wire word_t hash_in,
    output logic       valid_out,
    output word_t      hash_out,
    output word_t      float_out
);

    // stage 1: leading one position
    logic       s1_valid_reg;
    word_t      s1_hash_reg;
    logic [4:0] s1_msb_reg;
    logic [4:0] s1_msb_next;
    logic       s1_zero_reg;

    // stage 2: normalised word
    logic       s2_valid_reg;
    word_t      s2_hash_reg;
    word_t      s2_norm_reg;
    word_t      s2_norm_next;
    logic [4:0] s2_msb_reg;
    logic       s2_zero_reg;

    // stage 3: rounded result
    logic       s3_valid_reg;
    word_t      s3_hash_reg;
    word_t      s3_float_reg;
    word_t      s3_float_next;

    logic [24:0] mant_rnd;
    logic        round_up;
    logic [7:0]  exp_biased;

    always_comb
    begin
        s1_msb_next = 5'd0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (hash_in[i])
            begin
                s1_msb_next = 5'(i);
            end
        end
    end

    assign s2_norm_next = s1_hash_reg << (5'd31 - s1_msb_reg);

    // guard bit plus sticky; ties go to the even significand
    assign round_up   = s2_norm_reg[7] & ((|s2_norm_reg[6:0]) | s2_norm_reg[8]);
    assign mant_rnd   = {1'b0, s2_norm_reg[31:8]} + 25'(round_up);
    assign exp_biased = 8'(s2_msb_reg) + EXP_OFFSET + 8'(mant_rnd[24]);

    always_comb
    begin
        if (s2_zero_reg)
        begin
            s3_float_next = '0;
        end
        else
        begin
            s3_float_next = {1'b0, exp_biased, (mant_rnd[24] ? 23'd0 : mant_rnd[22:0])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_hash_reg  <= hash_in;
            s1_msb_reg   <= s1_msb_next;
            s1_zero_reg  <= (hash_in == '0);
            s2_hash_reg  <= s1_hash_reg;
            s2_norm_reg  <= s2_norm_next;
            s2_msb_reg   <= s1_msb_reg;
            s2_zero_reg  <= s1_zero_reg;
            s3_hash_reg  <= s2_hash_reg;
            s3_float_reg <= s3_float_next;
        end
    end

    assign valid_out = s3_valid_reg;
    assign hash_out  = s3_hash_reg;
    assign float_out = s3_float_reg;

endmodule

`default_nettype wire
